// ----- hdl/ils_pkg.sv -----
// Package for the indexed list store: field widths, request and status codes,
// and the control structs passed between the sequencer and the walk unit.
// No dependencies.
package ils_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 11;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] READ_MISS = '1;

  typedef struct packed {
    logic start;
    logic up;
    logic step;
    logic put;
    logic rd;
  } walk_cmd_t;

  typedef struct packed {
    logic at_end;
    logic pend;
  } walk_stat_t;

endpackage

// ----- hdl/ils_if.sv -----
// Handshake channels of the indexed list store: request and response.
// Depends on ils_pkg for the field widths.
interface ils_req_if import ils_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface ils_rsp_if import ils_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [ST_W-1:0]          status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink (input valid, input read_value, input status, output ready);
endinterface

// ----- hdl/ils_walk.sv -----
// Walk unit: the element memory and the shared index stepper that moves
// elements up or down by one slot per cycle. Depends on ils_pkg.
module ils_walk import ils_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  walk_cmd_t                cmd,
  input  logic [$clog2(CAPACITY+1)-1:0] start_idx,
  input  logic [$clog2(CAPACITY+1)-1:0] stop_idx,
  input  logic signed [WORD_W-1:0] word,
  output logic signed [WORD_W-1:0] rdata,
  output walk_stat_t               stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY+1);

  logic signed [WORD_W-1:0] mem [CAPACITY];

  logic [LW-1:0]            cur;
  logic [LW-1:0]            stop;
  logic                     up;
  logic [AW-1:0]            wa;
  logic                     pend;
  logic [LW-1:0]            nxt;
  logic                     at_end;
  logic                     re;
  logic                     we;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic signed [WORD_W-1:0] wdata;

  always_comb begin
    nxt    = up ? cur - LW'(1) : cur + LW'(1);
    at_end = up ? (cur == stop) : (nxt == stop);
    re     = cmd.rd || (cmd.step && !at_end);
    raddr  = cmd.rd ? start_idx[AW-1:0] : nxt[AW-1:0];
    we     = cmd.put || (cmd.step && pend);
    waddr  = cmd.put ? cur[AW-1:0] : wa;
    wdata  = cmd.put ? word : rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.start) begin
      pend <= 1'b0;
    end else if (cmd.step) begin
      pend <= !at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur  <= start_idx;
      stop <= stop_idx;
      up   <= cmd.up;
    end else if (cmd.step && !at_end) begin
      cur <= nxt;
      wa  <= cur[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign stat.at_end = at_end;
  assign stat.pend   = pend;

endmodule

// ----- hdl/ils_ctrl.sv -----
// Sequencer of the indexed list store: request decode, length count, the
// walk commands and the response register. Depends on ils_pkg and ils_if.
module ils_ctrl import ils_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  ils_req_if.sink                  req,
  ils_rsp_if.source                rsp,
  output walk_cmd_t                cmd,
  output logic [$clog2(CAPACITY+1)-1:0] start_idx,
  output logic [$clog2(CAPACITY+1)-1:0] stop_idx,
  output logic signed [WORD_W-1:0] word,
  input  logic signed [WORD_W-1:0] rdata,
  input  walk_stat_t               stat
);

  localparam int LW = $clog2(CAPACITY+1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [LW-1:0]            len, len_next;
  logic                     is_ins, is_ins_next;
  logic signed [WORD_W-1:0] res_value, res_value_next;
  logic [ST_W-1:0]          res_status, res_status_next;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_value;
  logic [ST_W-1:0]          out_status;
  logic                     load;
  logic                     full;
  logic [CW-1:0]            pos_c;
  logic [CW-1:0]            len_c;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;

  always_comb begin
    pos_c           = CW'(req.position);
    len_c           = CW'(len);
    full            = (len == LW'(CAPACITY));
    cmd             = '0;
    start_idx       = pos_c[LW-1:0];
    stop_idx        = len;
    state_next      = state;
    len_next        = len;
    is_ins_next     = is_ins;
    res_value_next  = res_value;
    res_status_next = res_status;
    load            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_value_next  = '0;
          res_status_next = ST_DONE;
          state_next      = S_FIN;
          unique case (req.operation)
            OP_READ: begin
              if (pos_c < len_c) begin
                cmd.rd     = 1'b1;
                state_next = S_RDWAIT;
              end else begin
                res_value_next  = READ_MISS;
                res_status_next = ST_RANGE;
              end
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                cmd.start   = 1'b1;
                cmd.up      = 1'b1;
                start_idx   = len;
                stop_idx    = (req.operation == OP_INS_HEAD) ? '0 : len;
                is_ins_next = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            OP_INS_AT: begin
              if (pos_c > len_c) begin
                res_status_next = ST_RANGE;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else begin
                cmd.start   = 1'b1;
                cmd.up      = 1'b1;
                start_idx   = len;
                stop_idx    = pos_c[LW-1:0];
                is_ins_next = 1'b1;
                state_next  = S_SHIFT;
              end
            end
            OP_DELETE: begin
              if (pos_c >= len_c) begin
                res_status_next = ST_RANGE;
              end else begin
                cmd.start   = 1'b1;
                start_idx   = pos_c[LW-1:0];
                stop_idx    = len;
                is_ins_next = 1'b0;
                state_next  = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_value_next = rdata;
        state_next     = S_FIN;
      end
      S_SHIFT: begin
        if (stat.at_end && !stat.pend) begin
          if (is_ins) begin
            cmd.put  = 1'b1;
            len_next = len + LW'(1);
          end else begin
            len_next = len - LW'(1);
          end
          state_next = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_ins     <= is_ins_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    if (req.valid && req.ready) begin
      word <= req.value;
    end
    if (load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

`ifndef ASSERT_OFF
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_SHIFT) |=> (len == $past(len)))
    else $error("length changed outside a shift");

  a_put_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (!stat.pend && !cmd.step && stat.at_end))
    else $error("insert write collides with a pending move");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || rsp.ready)) |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule

// ----- hdl/indexed_list_store_core.sv -----
// Indexed list store: an ordered sequence of signed 32-bit words of bounded
// capacity, served one request at a time.
// Depends on ils_pkg, ils_if, ils_ctrl and ils_walk.
//
// Channels: req carries operation, position and value; rsp carries
// read_value and status, one response word per request word, in order.
// req.ready is high only while the sequencer is idle; one request is worked
// on at a time.
// Path from acceptance to the response register: a read passes through S_RDWAIT
// and then S_FIN; an insert or a delete passes through S_SHIFT, where n elements
// move one slot (from 1 to CAPACITY - 1, or none), and then S_FIN. The shift
// time is set by the element memory, which moves one element per cycle through
// its single read and write port. A request that is refused for range or
// capacity, or that carries an unused operation code, goes straight to S_FIN.
// Reset (rst, synchronous) empties the list and clears the sequencer and the
// response valid flag; the element memory is not cleared, as only entries
// below the length are ever read.
// When the receiver holds rsp.ready low, the next request is still accepted
// and worked on; it then waits until the pending response has been taken.
module indexed_list_store_core import ils_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  localparam int LW = $clog2(CAPACITY+1);

  walk_cmd_t                cmd;
  walk_stat_t               stat;
  logic [LW-1:0]            start_idx;
  logic [LW-1:0]            stop_idx;
  logic signed [WORD_W-1:0] word;
  logic signed [WORD_W-1:0] rdata;

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .start_idx (start_idx),
    .stop_idx  (stop_idx),
    .word      (word),
    .rdata     (rdata),
    .stat      (stat)
  );

  ils_walk #(
    .CAPACITY (CAPACITY)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .start_idx (start_idx),
    .stop_idx  (stop_idx),
    .word      (word),
    .rdata     (rdata),
    .stat      (stat)
  );

endmodule
